### rtl/hkrt_pkg.sv
// Package for the HID key rollover table: slot count, item types,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package hkrt_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_KEYS = 6;
    localparam int IDX_W       = $clog2(KEY_SLOTS);

    typedef logic [IDX_W-1:0] slot_idx_t;
    localparam slot_idx_t LAST_IDX = slot_idx_t'(KEY_SLOTS - 1);

    typedef enum logic [1:0] {
        KIND_PRESS       = 2'd0,
        KIND_RELEASE     = 2'd1,
        KIND_RELEASE_ALL = 2'd2,
        KIND_SEND        = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] keycode;
        logic       force_req;
        logic       host_ready;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic       any_key;
        logic       transfer_request;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PSCAN,
        ST_PSTORE,
        ST_RSCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic store;
        logic shift;
        logic clear;
        logic send;
        logic ok_we;
        logic ok_val;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  code_zero;
        logic  hit;
        logic  at_last;
        logic  free_found;
        logic  out_free;
    } dp_status_t;

endpackage

### rtl/hkrt_datapath.sv
// Datapath of the HID key rollover table: key slots, scan index, flags
// and the result register. Depends on hkrt_pkg.
module hkrt_datapath
    import hkrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  logic       out_ready,
    output logic       out_valid,
    output out_item_t  out_data
);

    logic [7:0] held_reg [KEY_SLOTS];
    logic       dirty_reg;
    in_item_t   item_reg;
    slot_idx_t  idx_reg;
    slot_idx_t  free_idx_reg;
    logic       free_found_reg;
    logic       ok_reg;
    logic       xfer_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic [7:0] cur_key;
    logic [7:0] shift_src;
    logic       hit;
    logic       at_last;
    logic [7:0] report_keys [REPORT_KEYS];
    logic       flag_next;
    logic       prefix_ok;

    assign cur_key   = held_reg[idx_reg];
    assign hit       = (cur_key == item_reg.keycode);
    assign at_last   = (idx_reg == LAST_IDX);
    assign shift_src = at_last ? 8'd0 : held_reg[idx_reg + slot_idx_t'(1)];
    assign flag_next = (held_reg[0] != 8'd0);

    assign status.kind       = item_reg.kind;
    assign status.code_zero  = (item_reg.keycode == 8'd0);
    assign status.hit        = hit;
    assign status.at_last    = at_last;
    assign status.free_found = free_found_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Slots beyond the table read as empty in the report.
    for (genvar g = 0; g < REPORT_KEYS; g++) begin : g_report
        if (g < KEY_SLOTS) begin : g_slot
            assign report_keys[g] = held_reg[g];
        end else begin : g_empty
            assign report_keys[g] = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                held_reg[i] <= 8'd0;
            end
            dirty_reg      <= 1'b0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
            end
            if (cmd.scan) begin
                if (cur_key == 8'd0 && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (!hit && !at_last) begin
                    idx_reg <= idx_reg + slot_idx_t'(1);
                end
            end
            if (cmd.store) begin
                held_reg[free_idx_reg] <= item_reg.keycode;
                dirty_reg              <= 1'b1;
            end
            if (cmd.shift) begin
                held_reg[idx_reg] <= shift_src;
                dirty_reg         <= 1'b1;
                if (!at_last) begin
                    idx_reg <= idx_reg + slot_idx_t'(1);
                end
            end
            if (cmd.clear) begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    held_reg[i] <= 8'd0;
                end
                dirty_reg <= 1'b1;
            end
            if (cmd.send && (dirty_reg || item_reg.force_req) && item_reg.host_ready) begin
                dirty_reg <= 1'b0;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            item_reg <= in_data;
            ok_reg   <= 1'b0;
            xfer_reg <= 1'b0;
        end
        if (cmd.scan && cur_key == 8'd0 && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.ok_we) begin
            ok_reg <= cmd.ok_val;
        end
        if (cmd.send) begin
            if (dirty_reg || item_reg.force_req) begin
                xfer_reg <= 1'b1;
                ok_reg   <= item_reg.host_ready;
            end else begin
                ok_reg <= 1'b1;
            end
        end
        if (cmd.finish) begin
            out_data_reg.ok               <= ok_reg;
            out_data_reg.any_key          <= flag_next;
            out_data_reg.transfer_request <= xfer_reg;
            out_data_reg.key_0            <= report_keys[0];
            out_data_reg.key_1            <= report_keys[1];
            out_data_reg.key_2            <= report_keys[2];
            out_data_reg.key_3            <= report_keys[3];
            out_data_reg.key_4            <= report_keys[4];
            out_data_reg.key_5            <= report_keys[5];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Occupied slots form a prefix: no key after an empty slot.
    always_comb begin
        prefix_ok = 1'b1;
        for (int i = 0; i + 1 < KEY_SLOTS; i++) begin
            if (held_reg[i] == 8'd0 && held_reg[i+1] != 8'd0) begin
                prefix_ok = 1'b0;
            end
        end
    end

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n) prefix_ok)
        else $error("held keys are not packed");

    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> free_found_reg && held_reg[free_idx_reg] == 8'd0)
        else $error("store into an occupied or unknown slot");

    a_any_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.any_key == (out_data_reg.key_0 != 8'd0)))
        else $error("any_key disagrees with slot 0");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("waiting result dropped or changed");

endmodule

### rtl/hkrt_controller.sv
// Controller of the HID key rollover table: sequences scan, store, shift, clear, send
// and result load. Depends on hkrt_pkg.
module hkrt_controller
    import hkrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.kind)
                    KIND_PRESS:   state_next = status.code_zero ? ST_FINISH : ST_PSCAN;
                    KIND_RELEASE: state_next = status.code_zero ? ST_FINISH : ST_RSCAN;
                    default:      state_next = ST_FINISH;
                endcase
            end
            ST_PSCAN: begin
                if (status.hit) begin
                    state_next = ST_FINISH;
                end else if (status.at_last) begin
                    state_next = ST_PSTORE;
                end
            end
            ST_PSTORE: state_next = ST_FINISH;
            ST_RSCAN: begin
                if (status.hit) begin
                    state_next = ST_SHIFT;
                end else if (status.at_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                if (status.at_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE: begin
                unique case (status.kind)
                    KIND_PRESS: begin
                        cmd.ok_we  = status.code_zero;
                        cmd.ok_val = 1'b1;
                    end
                    KIND_RELEASE: begin
                        cmd.ok_we  = status.code_zero;
                        cmd.ok_val = 1'b0;
                    end
                    KIND_RELEASE_ALL: begin
                        cmd.clear  = 1'b1;
                        cmd.ok_we  = 1'b1;
                        cmd.ok_val = 1'b1;
                    end
                    default: cmd.send = 1'b1;
                endcase
            end
            ST_PSCAN: begin
                cmd.scan   = 1'b1;
                cmd.ok_we  = status.hit;
                cmd.ok_val = 1'b1;
            end
            ST_PSTORE: begin
                cmd.store  = status.free_found;
                cmd.ok_we  = 1'b1;
                cmd.ok_val = status.free_found;
            end
            ST_RSCAN: begin
                cmd.scan   = 1'b1;
                cmd.ok_we  = status.hit || status.at_last;
                cmd.ok_val = status.hit;
            end
            ST_SHIFT:  cmd.shift  = 1'b1;
            ST_FINISH: cmd.finish = status.out_free;
            default: ;
        endcase
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DECODE)
        else $error("accepted transaction not decoded");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.store, cmd.shift, cmd.clear, cmd.send}))
        else $error("conflicting table commands");

endmodule

### rtl/hid_key_rollover_table.sv
// HID key rollover table, top level: joins the controller and datapath.
// Scan and shift walk one slot a cycle.
// Throughput: one transaction at a time; in_ready returns the cycle after the result register loads.
// Press and release walk the slots; zero keycode, release-all and send go from decode straight to finish; each transaction ends back in idle.
// Reset (rst_n low, asynchronous): all slots empty, flags clear, no result pending, ready for input.
// Depends on hkrt_pkg, hkrt_controller, hkrt_datapath.
module hid_key_rollover_table
    import hkrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // Commands from the controller, status back from the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence each transaction: decode, then scan the slots and store or shift, or clear, or send.
    hkrt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the key slots and flags; the result register decouples the output
    // so a waiting result does not block the table walk of the next transaction.
    hkrt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
